@@ design/sbes_pkg.sv @@
`timescale 1ns / 1ps

package sbes_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_MASK = 2'd2;

    localparam int RANDOM_W = 16;
    localparam int ENTRY_W = 4;
    localparam int COUNT_REG_W = 5;
    localparam int MASK_REG_W = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEQ,
        S_BAG,
        S_COUNT,
        S_MUL,
        S_FIND,
        S_DONE
    } sbes_state_t;

    typedef struct packed {
        logic               found;
        logic [ENTRY_W-1:0] entry;
    } sbes_result_t;

endpackage

@@ design/sbes_engine.sv @@
`timescale 1ns / 1ps

module sbes_engine #(
    parameter int MAX_ENTRIES = sbes_pkg::MAX_ENTRIES_DEF,
    parameter int IDX_W = $clog2(MAX_ENTRIES),
    parameter int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sbes_pkg::RANDOM_W-1:0] random_value,
    input  logic                          queue_mode,
    input  logic [CNT_W-1:0]              count,
    input  logic [MAX_ENTRIES-1:0]        use_mask,
    input  logic [MAX_ENTRIES-1:0]        vis_mask,
    output logic                          idle,
    output logic                          res_valid,
    input  logic                          res_take,
    output sbes_pkg::sbes_result_t        res
);

    import sbes_pkg::*;

    localparam int PROD_W = RANDOM_W + CNT_W;
    localparam int EX_W = IDX_W + ENTRY_W;

    sbes_state_t state_reg, state_next;

    logic [IDX_W-1:0]       cursor_reg, cursor_next;
    logic [MAX_ENTRIES-1:0] bag_reg, bag_next;
    logic [IDX_W-1:0]       prev_entry_reg, prev_entry_next;
    logic                   prev_valid_reg, prev_valid_next;

    logic [RANDOM_W-1:0]    rnd_reg, rnd_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [CNT_W-1:0]       steps_reg, steps_next;
    logic [CNT_W-1:0]       size_reg, size_next;
    logic [CNT_W-1:0]       target_reg, target_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       chosen_reg, chosen_next;

    logic [CNT_W-1:0]       cur_inc;
    logic [IDX_W-1:0]       cursor_step;
    logic                   seq_hit;
    logic [CNT_W-1:0]       steps_inc;
    logic                   bag_bit;
    logic [CNT_W-1:0]       size_sum;
    logic                   scan_last;
    logic [MAX_ENTRIES-1:0] bag_masked;
    logic [PROD_W-1:0]      prod;
    logic                   hit;
    logic                   collide;
    logic [CNT_W-1:0]       target_inc;
    logic [EX_W-1:0]        chosen_ext;

    assign cur_inc     = CNT_W'(cursor_reg) + CNT_W'(1);
    assign cursor_step = (cur_inc >= count) ? '0 : cur_inc[IDX_W-1:0];
    assign seq_hit     = vis_mask[cursor_step];
    assign steps_inc   = steps_reg + CNT_W'(1);
    assign bag_bit     = bag_reg[idx_reg];
    assign size_sum    = size_reg + CNT_W'(bag_bit);
    assign scan_last   = (idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign bag_masked  = bag_reg & use_mask;
    assign prod        = PROD_W'(rnd_reg) * PROD_W'(size_reg);
    assign hit         = bag_bit && (steps_reg == target_reg);
    assign collide     = prev_valid_reg && (idx_reg == prev_entry_reg)
                         && (size_reg != CNT_W'(1));
    assign target_inc  = target_reg + CNT_W'(1);
    assign chosen_ext  = EX_W'(chosen_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (count == '0)
                        state_next = S_DONE;
                    else if (queue_mode)
                        state_next = S_BAG;
                    else
                        state_next = S_SEQ;
                end
            end
            S_SEQ:
            begin
                if (seq_hit || (steps_inc == count))
                    state_next = S_DONE;
            end
            S_BAG:
                state_next = S_COUNT;
            S_COUNT:
            begin
                if (scan_last)
                    state_next = (size_sum == '0) ? S_DONE : S_MUL;
            end
            S_MUL:
                state_next = S_FIND;
            S_FIND:
            begin
                if (hit && !collide)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cursor_next     = cursor_reg;
        bag_next        = bag_reg;
        prev_entry_next = prev_entry_reg;
        prev_valid_next = prev_valid_reg;
        rnd_next        = rnd_reg;
        idx_next        = idx_reg;
        steps_next      = steps_reg;
        size_next       = size_reg;
        target_next     = target_reg;
        found_next      = found_reg;
        chosen_next     = chosen_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rnd_next    = random_value;
                    found_next  = 1'b0;
                    chosen_next = '0;
                    steps_next  = '0;
                    idx_next    = '0;
                    size_next   = '0;
                end
            end
            S_SEQ:
            begin
                cursor_next = cursor_step;
                steps_next  = steps_inc;
                if (seq_hit)
                begin
                    found_next  = 1'b1;
                    chosen_next = cursor_step;
                end
            end
            S_BAG:
            begin
                bag_next  = (bag_masked == '0) ? vis_mask : bag_masked;
                idx_next  = '0;
                size_next = '0;
            end
            S_COUNT:
            begin
                size_next = size_sum;
                idx_next  = scan_last ? '0 : idx_reg + IDX_W'(1);
            end
            S_MUL:
            begin
                target_next = prod[RANDOM_W +: CNT_W];
                idx_next    = '0;
                steps_next  = '0;
            end
            S_FIND:
            begin
                if (hit)
                begin
                    if (collide)
                    begin
                        target_next = (target_inc >= size_reg) ? '0 : target_inc;
                        idx_next    = '0;
                        steps_next  = '0;
                    end
                    else
                    begin
                        bag_next[idx_reg] = 1'b0;
                        prev_entry_next   = idx_reg;
                        prev_valid_next   = 1'b1;
                        found_next        = 1'b1;
                        chosen_next       = idx_reg;
                    end
                end
                else
                begin
                    if (bag_bit)
                        steps_next = steps_inc;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.found = found_reg;
    assign res.entry = found_reg ? chosen_ext[ENTRY_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cursor_reg     <= IDX_W'(MAX_ENTRIES - 1);
            bag_reg        <= '0;
            prev_entry_reg <= '0;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            bag_reg        <= bag_next;
            prev_entry_reg <= prev_entry_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rnd_reg    <= rnd_next;
        idx_reg    <= idx_next;
        steps_reg  <= steps_next;
        size_reg   <= size_next;
        target_reg <= target_next;
        found_reg  <= found_next;
        chosen_reg <= chosen_next;
    end

endmodule

@@ design/shuffle_bag_entry_selector_core.sv @@
`timescale 1ns / 1ps

// Picks one entry per request out of up to MAX_ENTRIES, restricted to the visible
// entries in use. Sequential mode steps a round-robin cursor one entry per cycle
// through up to entry_count steps (capped at MAX_ENTRIES) to the next visible
// entry. Random mode refreshes the bag, counts its members with a
// one-bit-per-cycle scan over MAX_ENTRIES entries, forms the pick with one
// multiply of the 16-bit random value by the bag size, then scans the bag for
// the picked member, and scans once more if that member repeats the previous
// choice while the bag holds more than one member. The input is stalled while a
// request is in work; a finished result sits in an output register, so the next
// request can start while it waits to be taken.

module shuffle_bag_entry_selector_core #(
    parameter int MAX_ENTRIES = sbes_pkg::MAX_ENTRIES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sbes_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbes_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [sbes_pkg::RANDOM_W-1:0]   random_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            found,
    output logic [sbes_pkg::ENTRY_W-1:0]    entry
);

    import sbes_pkg::*;

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > COUNT_REG_W) ? CNT_W : COUNT_REG_W;
    localparam int VX_W = MAX_ENTRIES + MASK_REG_W;

    logic                   mode_reg;
    logic [COUNT_REG_W-1:0] count_reg;
    logic [MASK_REG_W-1:0]  vis_reg;

    logic [CNT_W-1:0]       count;
    logic [MAX_ENTRIES-1:0] use_mask;
    logic [VX_W-1:0]        vis_ext;
    logic [MAX_ENTRIES-1:0] vis_mask;

    logic                   eng_idle;
    logic                   res_valid;
    logic                   res_take;
    sbes_result_t           res;

    logic                   out_valid_reg;
    sbes_result_t           out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            count_reg <= '0;
            vis_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_QUEUE_MODE:   mode_reg  <= cfg_data[0];
                CFG_ENTRY_COUNT:  count_reg <= cfg_data[COUNT_REG_W-1:0];
                CFG_VISIBLE_MASK: vis_reg   <= cfg_data[MASK_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (CMP_W'(count_reg) > CMP_W'(MAX_ENTRIES))
            count = CNT_W'(MAX_ENTRIES);
        else
            count = CNT_W'(count_reg);
        for (int i = 0; i < MAX_ENTRIES; i++)
            use_mask[i] = (CNT_W'(i) < count);
    end

    assign vis_ext  = VX_W'(vis_reg);
    assign vis_mask = vis_ext[MAX_ENTRIES-1:0] & use_mask;

    sbes_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_valid && !in_stall),
        .random_value (random_value),
        .queue_mode   (mode_reg),
        .count        (count),
        .use_mask     (use_mask),
        .vis_mask     (vis_mask),
        .idle         (eng_idle),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    assign in_stall = !eng_idle;
    assign res_take = !out_valid_reg || !out_stall;

    // hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_take)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign found     = out_reg.found;
    assign entry     = out_reg.entry;

endmodule
